>>> src/fbpa_pkg.sv
// shared constants, codes and types of the fixed block pool allocator
package fbpa_pkg;

  localparam int ARENA_BYTES_DEF = 16384;
  localparam int ALIGN_BYTES_DEF = 8;

  localparam int FUNC_W   = 2;
  localparam int BYTES_W  = 15;
  localparam int BOFF_W   = 14;
  localparam int OFF_W    = 14;
  localparam int BSIZE_W  = 15;
  localparam int BCNT_W   = 12;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_SEL_BIT = 2;

  localparam logic [BSIZE_W-1:0] BSIZE_RST = BSIZE_W'(8);
  localparam logic [BCNT_W-1:0]  BCNT_RST  = '0;

  localparam logic REG_BSIZE = 1'b0;
  localparam logic REG_BCNT  = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_RAW,
    FN_INIT,
    FN_ALLOC,
    FN_FREE
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIT,
    S_WALK,
    S_POP,
    S_EMIT
  } state_t;

endpackage

>>> src/fbpa_link_mem.sv
// free list link memory, one entry per granule, registered read
module fbpa_link_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/fixed_block_pool_allocator.sv
// fixed block pool allocator: bump arena, pool init walk, lifo free list in a link memory
// raw allocation and free: the result is formed in the execute state, one transaction each
// pool allocate: execute then pop, the pop waiting on the registered read of the link memory
// pool init: execute, fit, then one walk step and one link memory write per carved block
// the next transaction is taken once the current one has left for the output register
// sync active-low reset: whole arena free, list empty, link memory not cleared
module fixed_block_pool_allocator #(
  parameter int ARENA_BYTES = fbpa_pkg::ARENA_BYTES_DEF,
  parameter int ALIGN_BYTES = fbpa_pkg::ALIGN_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: byte_count [14:0], block_offset [28:15], zero pad
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fbpa_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: func
  input  logic [fbpa_pkg::FUNC_W-1:0]         in_tuser,
  // out_tdata: offset [13:0], zero pad
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fbpa_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: ok
  output logic                                out_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fbpa_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int GRAN   = ARENA_BYTES / ALIGN_BYTES;
  localparam int ALG    = $clog2(ALIGN_BYTES);
  localparam int TOPW   = $clog2(ARENA_BYTES + 1);
  localparam int GW     = $clog2(GRAN + 1);
  localparam int GIW    = $clog2(GRAN);
  localparam int SZW    = fbpa_pkg::BSIZE_W + 1;
  localparam int STW    = SZW - ALG;
  localparam int PW     = SZW + fbpa_pkg::BCNT_W;
  localparam int CURW   = ((GW > STW) ? GW : STW) + 1;
  localparam int CW     = (TOPW > fbpa_pkg::BYTES_W) ? TOPW : fbpa_pkg::BYTES_W;
  localparam int FIDXW  = fbpa_pkg::BOFF_W - ALG;
  localparam int OFF_W  = fbpa_pkg::OFF_W;
  localparam int BYTES_W = fbpa_pkg::BYTES_W;
  localparam int BOFF_W = fbpa_pkg::BOFF_W;
  localparam int BCNT_W = fbpa_pkg::BCNT_W;
  localparam int BSIZE_W = fbpa_pkg::BSIZE_W;

  localparam logic [GW-1:0]   NULL_LINK = GW'(GRAN);
  localparam logic [TOPW-1:0] TOP_MASK  = ~TOPW'(ALIGN_BYTES - 1);
  localparam logic [SZW-1:0]  SZ_MASK   = ~SZW'(ALIGN_BYTES - 1);

  fbpa_pkg::state_t st_r, st_nxt;
  fbpa_pkg::func_t  op_r;

  logic [BYTES_W-1:0] bytes_r;
  logic [BOFF_W-1:0]  boff_r;
  logic [TOPW-1:0]    top_r, top_nxt;
  logic [GW-1:0]      head_r, head_nxt;
  logic [PW-1:0]      prod_r, prod_nxt;
  logic [STW-1:0]     step_r, step_nxt;
  logic [CURW-1:0]    cur_r, cur_nxt;
  logic [BCNT_W-1:0]  left_r, left_nxt;
  logic [GW-1:0]      pop_r, pop_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [OFF_W-1:0]   res_off_r, res_off_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [OFF_W-1:0]   out_off_r, out_off_nxt;
  logic [BSIZE_W-1:0] bs_r;
  logic [BCNT_W-1:0]  bc_r;

  logic               fin;
  logic               fin_ok;
  logic [OFF_W-1:0]   fin_off;
  logic               slot_free;
  logic               in_acc;
  logic               cfg_wr;

  logic [SZW-1:0]     size_raw, size;
  logic [CW-1:0]      raw_rem;
  logic               raw_fit;
  logic [TOPW-1:0]    raw_top;
  logic               init_fit;
  logic [TOPW-1:0]    init_top;
  logic [FIDXW-1:0]   fidx;
  logic               fidx_ok;
  logic               head_ok;
  logic               cur_ok;

  logic               mem_we;
  logic [GIW-1:0]     mem_waddr;
  logic [GW-1:0]      mem_wdata;
  logic [GW-1:0]      mem_rdata;

  fbpa_link_mem #(
    .DEPTH (GRAN),
    .AW    (GIW),
    .DW    (GW)
  ) u_link_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (head_r[GIW-1:0]),
    .rd_data (mem_rdata)
  );

  assign in_tready  = (st_r == fbpa_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {{(fbpa_pkg::OUT_TDATA_W - OFF_W){1'b0}}, out_off_r};

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[fbpa_pkg::CFG_SEL_BIT] == fbpa_pkg::REG_BCNT) ?
                      fbpa_pkg::CFG_DATA_W'(bc_r) : fbpa_pkg::CFG_DATA_W'(bs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= fbpa_pkg::BSIZE_RST;
      bc_r <= fbpa_pkg::BCNT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[fbpa_pkg::CFG_SEL_BIT] == fbpa_pkg::REG_BCNT) begin
        bc_r <= cfg_pwdata[BCNT_W-1:0];
      end else begin
        bs_r <= cfg_pwdata[BSIZE_W-1:0];
      end
    end
  end

  // arithmetic for each function
  assign size_raw = (SZW'(bs_r) + SZW'(ALIGN_BYTES - 1)) & SZ_MASK;
  assign size     = (size_raw == '0) ? SZW'(ALIGN_BYTES) : size_raw;
  assign prod_nxt = PW'(size) * PW'(bc_r);
  assign step_nxt = size[SZW-1:ALG];

  assign raw_fit  = CW'(top_r) >= CW'(bytes_r);
  assign raw_rem  = CW'(top_r) - CW'(bytes_r);
  assign raw_top  = TOPW'(raw_rem) & TOP_MASK;

  assign init_fit = prod_r <= PW'(top_r);
  assign init_top = TOPW'(PW'(top_r) - prod_r) & TOP_MASK;

  assign fidx     = boff_r[BOFF_W-1:ALG];
  assign fidx_ok  = 32'(fidx) < 32'(GRAN);
  assign head_ok  = head_r < NULL_LINK;
  assign cur_ok   = 32'(cur_r) < 32'(GRAN);

  always_comb begin
    st_nxt      = st_r;
    top_nxt     = top_r;
    head_nxt    = head_r;
    cur_nxt     = cur_r;
    left_nxt    = left_r;
    pop_nxt     = pop_r;
    res_ok_nxt  = res_ok_r;
    res_off_nxt = res_off_r;
    fin         = 1'b0;
    fin_ok      = 1'b0;
    fin_off     = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = head_r;

    unique case (st_r)
      fbpa_pkg::S_IDLE: begin
        if (in_acc) begin
          st_nxt = fbpa_pkg::S_EXEC;
        end
      end
      fbpa_pkg::S_EXEC: begin
        unique case (op_r)
          fbpa_pkg::FN_RAW: begin
            fin = 1'b1;
            if (raw_fit) begin
              top_nxt = raw_top;
              fin_ok  = 1'b1;
              fin_off = OFF_W'(raw_top);
            end
          end
          fbpa_pkg::FN_INIT: begin
            head_nxt = NULL_LINK;
            st_nxt   = fbpa_pkg::S_FIT;
          end
          fbpa_pkg::FN_ALLOC: begin
            if (head_ok) begin
              pop_nxt = head_r;
              st_nxt  = fbpa_pkg::S_POP;
            end else begin
              fin = 1'b1;
            end
          end
          fbpa_pkg::FN_FREE: begin
            fin = 1'b1;
            if (fidx_ok) begin
              mem_we    = 1'b1;
              mem_waddr = GIW'(fidx);
              head_nxt  = GW'(fidx);
              fin_ok    = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      fbpa_pkg::S_FIT: begin
        if (init_fit) begin
          top_nxt     = init_top;
          cur_nxt     = CURW'(init_top >> ALG);
          left_nxt    = bc_r;
          res_ok_nxt  = 1'b1;
          res_off_nxt = OFF_W'(init_top);
          if (bc_r == '0) begin
            fin     = 1'b1;
            fin_ok  = 1'b1;
            fin_off = OFF_W'(init_top);
          end else begin
            st_nxt = fbpa_pkg::S_WALK;
          end
        end else begin
          fin = 1'b1;
        end
      end
      fbpa_pkg::S_WALK: begin
        if (cur_ok) begin
          mem_we    = 1'b1;
          mem_waddr = GIW'(cur_r);
          head_nxt  = GW'(cur_r);
        end
        cur_nxt  = cur_r + CURW'(step_r);
        left_nxt = left_r - BCNT_W'(1);
        if (left_r == BCNT_W'(1)) begin
          fin     = 1'b1;
          fin_ok  = res_ok_r;
          fin_off = res_off_r;
        end
      end
      fbpa_pkg::S_POP: begin
        head_nxt = mem_rdata;
        fin      = 1'b1;
        fin_ok   = 1'b1;
        fin_off  = OFF_W'({pop_r, {ALG{1'b0}}});
      end
      fbpa_pkg::S_EMIT: begin
        if (slot_free) begin
          st_nxt = fbpa_pkg::S_IDLE;
        end
      end
      default: begin
        st_nxt = fbpa_pkg::S_IDLE;
      end
    endcase

    if (fin) begin
      res_ok_nxt  = fin_ok;
      res_off_nxt = fin_off;
      st_nxt      = slot_free ? fbpa_pkg::S_IDLE : fbpa_pkg::S_EMIT;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_off_nxt   = out_off_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin && slot_free) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = fin_ok;
      out_off_nxt   = fin_off;
    end else if (st_r == fbpa_pkg::S_EMIT && slot_free) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = res_ok_r;
      out_off_nxt   = res_off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= fbpa_pkg::S_IDLE;
      top_r       <= TOPW'(ARENA_BYTES);
      head_r      <= NULL_LINK;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      top_r       <= top_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= fbpa_pkg::func_t'(in_tuser);
      bytes_r <= in_tdata[BYTES_W-1:0];
      boff_r  <= in_tdata[BYTES_W +: BOFF_W];
    end
    prod_r    <= prod_nxt;
    step_r    <= step_nxt;
    cur_r     <= cur_nxt;
    left_r    <= left_nxt;
    pop_r     <= pop_nxt;
    res_ok_r  <= res_ok_nxt;
    res_off_r <= res_off_nxt;
    out_ok_r  <= out_ok_nxt;
    out_off_r <= out_off_nxt;
  end

endmodule

>>> test/fixed_block_pool_allocator_tb.sv
// testbench for the fixed block pool allocator: directed table then random traffic against a predictor
`timescale 1ns / 100ps

module fixed_block_pool_allocator_tb;

  localparam int GRANULES     = fbpa_pkg::ARENA_BYTES_DEF / fbpa_pkg::ALIGN_BYTES_DEF;
  localparam int ALIGN        = fbpa_pkg::ALIGN_BYTES_DEF;
  localparam int OFF_W        = fbpa_pkg::OFF_W;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DIR_ROWS     = 29;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] offset;
  } grant_t;

  typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;

  // op rows: arg0 byte_count, arg1 block_offset; cfg rows: arg0 block_size, arg1 block_count
  typedef struct {
    row_kind_t       kind;
    fbpa_pkg::func_t fn;
    int unsigned     arg0;
    int unsigned     arg1;
    bit              typed;
    bit              t_ok;
    int unsigned     t_off;
  } dir_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [fbpa_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [fbpa_pkg::FUNC_W-1:0]      in_tuser;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [fbpa_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             cfg_psel;
  logic                             cfg_penable;
  logic                             cfg_pwrite;
  logic [fbpa_pkg::CFG_ADDR_W-1:0]  cfg_paddr;
  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_pwdata;
  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                             cfg_pready;

  // predictor state
  int unsigned top_ptr    = fbpa_pkg::ARENA_BYTES_DEF;
  int unsigned head_gran  = GRANULES;
  int unsigned next_gran [GRANULES];
  int unsigned cur_bsize  = 8;
  int unsigned cur_bcount = 0;

  grant_t      grants_due [$];
  int unsigned held [$];
  dir_row_t    dir_rows [0:DIR_ROWS-1];
  int          errors = 0;
  int unsigned cycles = 0;
  int unsigned rx_hold = 0;
  logic        quiet = 1'b0;

  fixed_block_pool_allocator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  function automatic void push_gran(int unsigned idx);
    next_gran[idx] = head_gran;
    head_gran      = idx;
  endfunction

  function automatic grant_t predict_pool_op(fbpa_pkg::func_t fn, int unsigned nbytes,
                                             int unsigned boff);
    grant_t          g;
    int unsigned     gsize;
    int unsigned     base;
    int unsigned     idx;
    longint unsigned total;
    g = '{ok: 1'b0, offset: '0};
    case (fn)
      fbpa_pkg::FN_RAW: begin
        if (nbytes <= top_ptr) begin
          top_ptr = (top_ptr - nbytes) & ~(ALIGN - 1);
          g = '{ok: 1'b1, offset: OFF_W'(top_ptr)};
        end
      end
      fbpa_pkg::FN_INIT: begin
        gsize = (cur_bsize + ALIGN - 1) & ~(ALIGN - 1);
        if (gsize == 0) gsize = ALIGN;
        total = longint'(gsize) * longint'(cur_bcount);
        head_gran = GRANULES;
        if (total <= longint'(top_ptr)) begin
          top_ptr = (top_ptr - int'(total)) & ~(ALIGN - 1);
          base = top_ptr;
          for (int unsigned i = 0; i < cur_bcount; i++) begin
            idx = (base + i * gsize) / ALIGN;
            if (idx < GRANULES) push_gran(idx);
          end
          g = '{ok: 1'b1, offset: OFF_W'(base)};
        end
      end
      fbpa_pkg::FN_ALLOC: begin
        if (head_gran < GRANULES) begin
          idx       = head_gran;
          head_gran = next_gran[idx];
          g = '{ok: 1'b1, offset: OFF_W'(idx * ALIGN)};
        end
      end
      default: begin
        idx = boff / ALIGN;
        if (idx < GRANULES) begin
          push_gran(idx);
          g = '{ok: 1'b1, offset: '0};
        end
      end
    endcase
    return g;
  endfunction

  task automatic send_op(input fbpa_pkg::func_t fn, input int unsigned nbytes,
                         input int unsigned boff,
                         input bit typed, input bit t_ok, input int unsigned t_off,
                         output grant_t got);
    int unsigned gap;
    gap = quiet ? 0 : draw_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= fbpa_pkg::IN_TDATA_W'({fbpa_pkg::BOFF_W'(boff), fbpa_pkg::BYTES_W'(nbytes)});
    do @(posedge clk); while (!in_tready);
    got = predict_pool_op(fn, nbytes, boff);
    if (typed) grants_due.push_back('{ok: t_ok, offset: OFF_W'(t_off)});
    else grants_due.push_back(got);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pool_reg(input logic idx, input int unsigned val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= fbpa_pkg::CFG_ADDR_W'(idx) << fbpa_pkg::CFG_SEL_BIT;
    cfg_pwdata  <= fbpa_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == fbpa_pkg::REG_BSIZE) cur_bsize = val & ((1 << fbpa_pkg::BSIZE_W) - 1);
    else cur_bcount = val & ((1 << fbpa_pkg::BCNT_W) - 1);
    @(posedge clk);
  endtask

  task automatic set_pool(input int unsigned bsize, input int unsigned bcount);
    drain_results();
    write_pool_reg(fbpa_pkg::REG_BSIZE, bsize);
    write_pool_reg(fbpa_pkg::REG_BCNT, bcount);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      rx_hold    <= draw_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (grants_due.size() == 0) begin
        $error("result with no transaction pending: ok=%0d offset=%0d", out_tuser, out_tdata);
        errors++;
      end else begin
        want = grants_due.pop_front();
        if (out_tuser !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_tuser);
          errors++;
        end
        if (out_tdata !== fbpa_pkg::OUT_TDATA_W'(want.offset)) begin
          $error("offset: expected %0d, got %0d", want.offset, out_tdata);
          errors++;
        end
      end
    end
  end

  initial begin
    grant_t          got;
    fbpa_pkg::func_t fn;
    int unsigned     nb;
    int unsigned     bo;
    int unsigned     r;
    int unsigned     k;
    int unsigned     bsz;
    int unsigned     bcnt;

    dir_rows = '{
      '{ROW_OP,  fbpa_pkg::FN_ALLOC, 0,     0,     1, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_RAW,   0,     16383, 1, 1, 0},
      '{ROW_OP,  fbpa_pkg::FN_RAW,   32767, 0,     1, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_RAW,   16385, 0,     1, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_INIT,  0,     0,     0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_RAW,   1,     0,     1, 1, 16376},
      '{ROW_CFG, fbpa_pkg::FN_RAW,   0,     3,     0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_INIT,  0,     0,     0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_ALLOC, 0,     0,     0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_ALLOC, 0,     0,     0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_ALLOC, 0,     0,     0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_ALLOC, 0,     0,     1, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_FREE,  0,     16361, 1, 1, 0},
      '{ROW_OP,  fbpa_pkg::FN_FREE,  32767, 16383, 1, 1, 0},
      '{ROW_OP,  fbpa_pkg::FN_FREE,  0,     0,     1, 1, 0},
      '{ROW_OP,  fbpa_pkg::FN_ALLOC, 0,     0,     0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_ALLOC, 0,     0,     0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_ALLOC, 0,     0,     0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_FREE,  0,     16352, 1, 1, 0},
      '{ROW_OP,  fbpa_pkg::FN_FREE,  0,     16352, 1, 1, 0},
      '{ROW_OP,  fbpa_pkg::FN_ALLOC, 0,     0,     0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_ALLOC, 0,     0,     0, 0, 0},
      '{ROW_CFG, fbpa_pkg::FN_RAW,   16384, 2048,  0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_INIT,  0,     0,     1, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_ALLOC, 0,     0,     1, 0, 0},
      '{ROW_CFG, fbpa_pkg::FN_RAW,   1,     2048,  0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_INIT,  0,     0,     1, 0, 0},
      '{ROW_CFG, fbpa_pkg::FN_RAW,   9,     1,     0, 0, 0},
      '{ROW_OP,  fbpa_pkg::FN_INIT,  0,     0,     0, 0, 0}
    };

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= fbpa_pkg::FN_RAW;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        set_pool(dir_rows[i].arg0, dir_rows[i].arg1);
      end else begin
        send_op(dir_rows[i].fn, dir_rows[i].arg0, dir_rows[i].arg1, dir_rows[i].typed,
                dir_rows[i].t_ok, dir_rows[i].t_off, got);
      end
    end
    send_op(fbpa_pkg::FN_RAW, 16384, 0, 1, 0, 0, got);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin bsz = 8; bcnt = 16; end
        1: begin bsz = $urandom_range(1, 40); bcnt = $urandom_range(1, 12); end
        2: begin bsz = 0; bcnt = 32; end
        3: begin bsz = $urandom_range(41, 300); bcnt = $urandom_range(1, 2); end
        4: begin bsz = $urandom_range(1, 64); bcnt = $urandom_range(0, 20); end
        default: begin bsz = 16384; bcnt = 2048; end
      endcase
      set_pool(bsz, bcnt);
      held.delete();
      send_op(fbpa_pkg::FN_INIT, $urandom_range(0, 32767), $urandom_range(0, 16383),
              0, 0, 0, got);
      repeat (100) begin
        if ($urandom_range(0, 39) == 0) quiet <= !quiet;
        nb = $urandom_range(0, 32767);
        bo = $urandom_range(0, 16383);
        r  = $urandom_range(0, 99);
        if (r < 5) begin
          fn = fbpa_pkg::FN_INIT;
        end else if (r < 18) begin
          fn = fbpa_pkg::FN_RAW;
          nb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 48);
        end else if (r < 55) begin
          fn = fbpa_pkg::FN_ALLOC;
        end else begin
          fn = fbpa_pkg::FN_FREE;
          if (r < 90 && held.size() != 0) begin
            k  = $urandom_range(0, held.size() - 1);
            bo = held[k];
            held.delete(k);
          end
        end
        send_op(fn, nb, bo, 0, 0, 0, got);
        if (fn == fbpa_pkg::FN_INIT) held.delete();
        else if (fn == fbpa_pkg::FN_ALLOC && got.ok) held.push_back(got.offset);
      end
    end

    in_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
